FILE: hw/rtl/bounded_ordered_list_engine_core_macros.svh
// assertion macros shared by the list engine rtl
// expects i_clk and i_rst_n in the scope where a macro is used
`ifndef BOUNDED_ORDERED_LIST_ENGINE_CORE_MACROS_SVH
`define BOUNDED_ORDERED_LIST_ENGINE_CORE_MACROS_SVH

// consequent checked in the same cycle as the antecedent
`define BOLE_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent checked in the cycle after the antecedent
`define BOLE_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hw/rtl/bole_pkg.sv
// types and codes for the bounded ordered list engine
// no dependencies; used by the interface users and the top level
`timescale 1ns / 1ps

package bole_pkg;

    localparam int OP_W  = 3;
    localparam int VAL_W = 32;
    localparam int POS_W = 7;
    localparam int ST_W  = 3;
    localparam int CNT_W = 7;

    typedef enum logic [OP_W-1:0] {
        OP_APPEND   = 3'd0,
        OP_DEL_HEAD = 3'd1,
        OP_DEL_TAIL = 3'd2,
        OP_DEL_POS  = 3'd3,
        OP_DEL_VAL  = 3'd4,
        OP_READ     = 3'd5
    } t_op;

    typedef enum logic [ST_W-1:0] {
        ST_OK       = 3'd0,
        ST_EMPTY    = 3'd1,
        ST_FULL     = 3'd2,
        ST_BADPOS   = 3'd3,
        ST_NOTFOUND = 3'd4
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_RESP
    } t_state;

    typedef struct packed {
        logic [OP_W-1:0]         op;
        logic signed [VAL_W-1:0] value;
        logic [POS_W-1:0]        position;
    } t_req;

    typedef struct packed {
        logic [ST_W-1:0]         status;
        logic [CNT_W-1:0]        count;
        logic signed [VAL_W-1:0] data;
        logic                    last;
    } t_rsp;

endpackage

FILE: hw/rtl/bole_if.sv
// valid/ready channel carrying one payload struct per transaction
// payload type is set per instance, normally from bole_pkg
`timescale 1ns / 1ps

interface bole_if #(
    parameter type T = logic
) ();
    logic valid;
    logic ready;
    T     payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

FILE: hw/rtl/bole_ram.sv
// generic single write port, single read port ram with registered read data
// no dependencies
`timescale 1ns / 1ps

module bole_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        // read data holds while no read is issued
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: hw/rtl/bounded_ordered_list_engine_core.sv
// bounded ordered list engine: list of up to DEPTH signed words in one ram
// depends on bole_pkg, bole_if, bole_ram and the assertion macro header
//
//   channel | dir | payload                        | transaction
//   i_req   | in  | op, value, position             | one list operation
//   o_rsp   | out | status, count, data, last      | one result, last marks the end
//
// append, delete tail and the empty, full and bad position cases respond from S_RESP
// delete head / position / value and read-out walk the list in S_SCAN,
//   one ram read per entry through the single read port, shifting entries down
// a stalled o_rsp holds the read-out scan; a new request is taken while the
//   previous response still waits in the output register
// synchronous reset empties the list at once; no clearing pass
`timescale 1ns / 1ps
`include "bounded_ordered_list_engine_core_macros.svh"

module bounded_ordered_list_engine_core #(
    parameter int DEPTH = 16
) (
    input logic i_clk,
    input logic i_rst_n,
    bole_if.sink   i_req,
    bole_if.source o_rsp
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    bole_pkg::t_state r_state, n_state;

    logic [bole_pkg::OP_W-1:0]          r_op, n_op;
    logic signed [bole_pkg::VAL_W-1:0]  r_value, n_value;
    logic [bole_pkg::POS_W-1:0]         r_pos, n_pos;
    logic [CW-1:0]                      r_count, n_count;
    logic [CW-1:0]                      r_ridx, n_ridx;
    logic                               r_pend, n_pend;
    logic [AW-1:0]                      r_pidx, n_pidx;
    logic                               r_found, n_found;
    logic [bole_pkg::ST_W-1:0]          r_stat, n_stat;
    logic                               r_ovalid, n_ovalid;
    bole_pkg::t_rsp                     r_orsp, n_orsp;

    logic                               ram_we;
    logic [AW-1:0]                      ram_waddr;
    logic [bole_pkg::VAL_W-1:0]         ram_wdata;
    logic                               ram_re;
    logic [AW-1:0]                      ram_raddr;
    logic [bole_pkg::VAL_W-1:0]         ram_rdata;

    logic acc, out_free, is_read, can_go, proc, issue, p_last, match, hit;

    bole_ram #(
        .WIDTH (bole_pkg::VAL_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign i_req.ready   = (r_state == bole_pkg::S_IDLE);
    assign acc           = i_req.valid && i_req.ready;
    assign out_free      = !r_ovalid || o_rsp.ready;
    assign is_read       = (r_op == bole_pkg::OP_READ);
    // read-out stalls while a fetched entry cannot be handed to the output register
    assign can_go        = !(r_pend && is_read && !out_free);
    assign proc          = (r_state == bole_pkg::S_SCAN) && can_go && r_pend;
    assign issue         = (r_state == bole_pkg::S_SCAN) && can_go && (r_ridx < r_count);
    assign p_last        = ((CW'(r_pidx) + CW'(1)) == r_count);
    assign hit           = !r_found && match;
    assign o_rsp.valid   = r_ovalid;
    assign o_rsp.payload = r_orsp;

    always_comb begin
        case (r_op)
            bole_pkg::OP_DEL_HEAD: match = (r_pidx == '0);
            bole_pkg::OP_DEL_POS:
                match = ((bole_pkg::POS_W'(r_pidx) + bole_pkg::POS_W'(1)) == r_pos);
            bole_pkg::OP_DEL_VAL:  match = (ram_rdata == r_value);
            default:               match = 1'b0;
        endcase
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            bole_pkg::S_IDLE: begin
                if (acc) begin
                    case (i_req.payload.op)
                        bole_pkg::OP_APPEND, bole_pkg::OP_DEL_TAIL: begin
                            n_state = bole_pkg::S_RESP;
                        end
                        bole_pkg::OP_READ, bole_pkg::OP_DEL_HEAD,
                        bole_pkg::OP_DEL_VAL: begin
                            n_state = (r_count == '0) ? bole_pkg::S_RESP
                                                      : bole_pkg::S_SCAN;
                        end
                        bole_pkg::OP_DEL_POS: begin
                            if (r_count == '0 || i_req.payload.position == '0 ||
                                i_req.payload.position > bole_pkg::POS_W'(r_count)) begin
                                n_state = bole_pkg::S_RESP;
                            end else begin
                                n_state = bole_pkg::S_SCAN;
                            end
                        end
                        default: n_state = bole_pkg::S_IDLE;
                    endcase
                end
            end
            bole_pkg::S_SCAN: begin
                if (proc && p_last) begin
                    n_state = is_read ? bole_pkg::S_IDLE : bole_pkg::S_RESP;
                end
            end
            bole_pkg::S_RESP: begin
                if (out_free) begin
                    n_state = bole_pkg::S_IDLE;
                end
            end
            default: n_state = bole_pkg::S_IDLE;
        endcase
    end

    // datapath, ram control and output register load
    always_comb begin
        n_op      = r_op;
        n_value   = r_value;
        n_pos     = r_pos;
        n_count   = r_count;
        n_ridx    = r_ridx;
        n_pend    = r_pend;
        n_pidx    = r_pidx;
        n_found   = r_found;
        n_stat    = r_stat;
        n_ovalid  = r_ovalid && !o_rsp.ready;
        n_orsp    = r_orsp;
        ram_we    = 1'b0;
        ram_waddr = r_count[AW-1:0];
        ram_wdata = r_value;
        ram_re    = 1'b0;
        ram_raddr = r_ridx[AW-1:0];

        case (r_state)
            bole_pkg::S_IDLE: begin
                if (acc) begin
                    n_op    = i_req.payload.op;
                    n_value = i_req.payload.value;
                    n_pos   = i_req.payload.position;
                    n_ridx  = '0;
                    n_pend  = 1'b0;
                    n_found = 1'b0;
                    n_stat  = bole_pkg::ST_OK;
                    case (i_req.payload.op)
                        bole_pkg::OP_APPEND: begin
                            if (r_count == CW'(DEPTH)) begin
                                n_stat = bole_pkg::ST_FULL;
                            end else begin
                                ram_we    = 1'b1;
                                ram_waddr = r_count[AW-1:0];
                                ram_wdata = i_req.payload.value;
                                n_count   = r_count + CW'(1);
                            end
                        end
                        bole_pkg::OP_DEL_TAIL: begin
                            if (r_count == '0) begin
                                n_stat = bole_pkg::ST_EMPTY;
                            end else begin
                                n_count = r_count - CW'(1);
                            end
                        end
                        bole_pkg::OP_READ, bole_pkg::OP_DEL_HEAD,
                        bole_pkg::OP_DEL_VAL: begin
                            if (r_count == '0) begin
                                n_stat = bole_pkg::ST_EMPTY;
                            end
                        end
                        bole_pkg::OP_DEL_POS: begin
                            if (r_count == '0) begin
                                n_stat = bole_pkg::ST_EMPTY;
                            end else if (i_req.payload.position == '0 ||
                                i_req.payload.position > bole_pkg::POS_W'(r_count)) begin
                                n_stat = bole_pkg::ST_BADPOS;
                            end
                        end
                        default: begin
                            n_stat = bole_pkg::ST_OK;
                        end
                    endcase
                end
            end
            bole_pkg::S_SCAN: begin
                if (issue) begin
                    ram_re = 1'b1;
                    n_ridx = r_ridx + CW'(1);
                    n_pend = 1'b1;
                    n_pidx = r_ridx[AW-1:0];
                end else if (can_go) begin
                    n_pend = 1'b0;
                end
                if (proc) begin
                    if (is_read) begin
                        n_ovalid       = 1'b1;
                        n_orsp.status  = bole_pkg::ST_OK;
                        n_orsp.count   = bole_pkg::CNT_W'(r_count);
                        n_orsp.data    = ram_rdata;
                        n_orsp.last    = p_last;
                    end else begin
                        // entries past the deleted one move down by one place
                        if (r_found) begin
                            ram_we    = 1'b1;
                            ram_waddr = r_pidx - AW'(1);
                            ram_wdata = ram_rdata;
                        end
                        if (hit) begin
                            n_found = 1'b1;
                        end
                        if (p_last) begin
                            if (r_found || hit) begin
                                n_count = r_count - CW'(1);
                                n_stat  = bole_pkg::ST_OK;
                            end else begin
                                n_stat  = bole_pkg::ST_NOTFOUND;
                            end
                        end
                    end
                end
            end
            bole_pkg::S_RESP: begin
                if (out_free) begin
                    n_ovalid      = 1'b1;
                    n_orsp.status = r_stat;
                    n_orsp.count  = bole_pkg::CNT_W'(r_count);
                    n_orsp.data   = '0;
                    n_orsp.last   = 1'b1;
                end
            end
            default: begin
                n_pend = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= bole_pkg::S_IDLE;
            r_count  <= '0;
            r_pend   <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_pend   <= n_pend;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op    <= n_op;
        r_value <= n_value;
        r_pos   <= n_pos;
        r_ridx  <= n_ridx;
        r_pidx  <= n_pidx;
        r_found <= n_found;
        r_stat  <= n_stat;
        r_orsp  <= n_orsp;
    end

    `BOLE_ASSERT_NOW(a_count_bound, 1'b1, r_count <= CW'(DEPTH), "entry count above depth")
    `BOLE_ASSERT_NOW(a_pend_in_scan, r_state != bole_pkg::S_SCAN, !r_pend,
        "read pending outside scan")
    `BOLE_ASSERT_NOW(a_no_rw_clash, ram_we && ram_re, ram_waddr != ram_raddr,
        "shift write hits read address")
    `BOLE_ASSERT_NEXT(a_count_step, i_rst_n,
        (r_count == $past(r_count)) || (r_count == $past(r_count) + CW'(1)) ||
        (r_count + CW'(1) == $past(r_count)), "count moved by more than one")

endmodule

FILE: verif/testbench.sv
// self-checking testbench for bounded_ordered_list_engine_core
// depends on bole_pkg, bole_if and the core rtl; a scoreboard class tracks the list contents
`timescale 1ns / 1ps

module testbench;

    localparam int LIST_DEPTH  = 16;
    localparam int RANDOM_OPS  = 220;
    localparam int SETTLE_CYC  = 3 * LIST_DEPTH + 10;

    // shadow copy of the list; predicts every result and checks what comes back
    class list_scoreboard #(int DEPTH = 16);
        logic signed [bole_pkg::VAL_W-1:0] entries [DEPTH];
        int unsigned                       fill;
        bole_pkg::t_rsp                    expected_results [$];
        int                                errors;
        int                                ops_seen;
        int                                results_checked;
        int                                status_seen [5];

        function new();
            fill            = 0;
            errors          = 0;
            ops_seen        = 0;
            results_checked = 0;
            foreach (status_seen[i]) status_seen[i] = 0;
        endfunction

        function void push_result(bole_pkg::t_status st,
                                  logic signed [bole_pkg::VAL_W-1:0] d, bit lst);
            bole_pkg::t_rsp e;
            e.status = st;
            e.count  = bole_pkg::CNT_W'(fill);
            e.data   = d;
            e.last   = lst;
            expected_results.push_back(e);
            status_seen[st]++;
        endfunction

        // close the gap left by removing the entry at a 0-based index
        function void remove_entry(int unsigned idx);
            for (int unsigned i = idx; i + 1 < fill; i++) entries[i] = entries[i + 1];
            fill--;
        endfunction

        function void note_request(bole_pkg::t_req r);
            bole_pkg::t_status st;
            int unsigned       hit;
            st  = bole_pkg::ST_OK;
            hit = 0;
            if (r.op > bole_pkg::OP_READ) return;    // unused op codes are dropped
            ops_seen++;
            if (r.op == bole_pkg::OP_READ) begin
                if (fill == 0) begin
                    push_result(bole_pkg::ST_EMPTY, '0, 1'b1);
                end else begin
                    for (int unsigned i = 0; i < fill; i++)
                        push_result(bole_pkg::ST_OK, entries[i], i + 1 == fill);
                end
                return;
            end
            if (r.op == bole_pkg::OP_APPEND) begin
                if (fill >= DEPTH) begin
                    st = bole_pkg::ST_FULL;
                end else begin
                    entries[fill] = r.value;
                    fill++;
                end
            end else if (fill == 0) begin
                st = bole_pkg::ST_EMPTY;
            end else begin
                case (r.op)
                    bole_pkg::OP_DEL_HEAD: remove_entry(0);
                    bole_pkg::OP_DEL_TAIL: fill--;
                    bole_pkg::OP_DEL_POS: begin
                        if (r.position == 0 || r.position > fill) st = bole_pkg::ST_BADPOS;
                        else remove_entry(r.position - 1);
                    end
                    default: begin
                        while (hit < fill && entries[hit] !== r.value) hit++;
                        if (hit < fill) remove_entry(hit);
                        else st = bole_pkg::ST_NOTFOUND;
                    end
                endcase
            end
            push_result(st, '0, 1'b1);
        endfunction

        function void check_result(bole_pkg::t_rsp got);
            bole_pkg::t_rsp want;
            if (expected_results.size() == 0) begin
                $display("%0t unexpected result: status %0d count %0d data %0d last %0d",
                         $time, got.status, got.count, got.data, got.last);
                errors++;
                return;
            end
            want = expected_results.pop_front();
            results_checked++;
            if (got.status !== want.status) begin
                $display("%0t status mismatch: expected %0d actual %0d",
                         $time, want.status, got.status);
                errors++;
            end
            if (got.count !== want.count) begin
                $display("%0t count mismatch: expected %0d actual %0d",
                         $time, want.count, got.count);
                errors++;
            end
            if (got.data !== want.data) begin
                $display("%0t data mismatch: expected %0d actual %0d",
                         $time, want.data, got.data);
                errors++;
            end
            if (got.last !== want.last) begin
                $display("%0t last mismatch: expected %0d actual %0d",
                         $time, want.last, got.last);
                errors++;
            end
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n;
    bit   no_gaps = 1'b0;

    list_scoreboard #(LIST_DEPTH) sb;

    bole_if #(.T(bole_pkg::t_req)) req_if ();
    bole_if #(.T(bole_pkg::t_rsp)) rsp_if ();

    bounded_ordered_list_engine_core #(
        .DEPTH(LIST_DEPTH)
    ) uut (
        .i_clk  (clk),
        .i_rst_n(rst_n),
        .i_req  (req_if),
        .o_rsp  (rsp_if)
    );

    always #6 clk = ~clk;

    function automatic bole_pkg::t_req make_req(bole_pkg::t_op op,
                                                logic signed [bole_pkg::VAL_W-1:0] v,
                                                logic [bole_pkg::POS_W-1:0] p);
        bole_pkg::t_req r;
        r.op       = op;
        r.value    = v;
        r.position = p;
        return r;
    endfunction

    // random idle cycles with junk payload, then hold valid until the transaction completes
    task automatic send_op(input bole_pkg::t_req r);
        logic [63:0] junk;
        while (!no_gaps && $urandom_range(0, 99) < 16) begin
            junk = {$urandom, $urandom};
            req_if.valid   <= 1'b0;
            req_if.payload <= junk[$bits(bole_pkg::t_req)-1:0];
            @(posedge clk);
        end
        req_if.valid   <= 1'b1;
        req_if.payload <= r;
        do @(posedge clk); while (!req_if.ready);
        sb.note_request(r);
    endtask

    task automatic wait_drained();
        req_if.valid <= 1'b0;
        do @(posedge clk); while (sb.expected_results.size() != 0);
    endtask

    function automatic logic signed [bole_pkg::VAL_W-1:0] pick_value();
        case ($urandom_range(0, 5))
            0:       return 32'sh8000_0000;
            1:       return 32'sh7fff_ffff;
            2, 3:    return int'($urandom_range(0, 15)) - 8;
            default: return $urandom;
        endcase
    endfunction

    task automatic send_random_op(input bit growing, output bit counted);
        bole_pkg::t_req                    r;
        int unsigned                       roll;
        int unsigned                       pos_hi;
        logic signed [bole_pkg::VAL_W-1:0] v;
        logic [bole_pkg::POS_W-1:0]        p;
        roll    = $urandom_range(0, 99);
        v       = pick_value();
        pos_hi  = (sb.fill == 0) ? 1 : sb.fill;
        p       = ($urandom_range(0, 9) < 7) ? bole_pkg::POS_W'($urandom_range(1, pos_hi))
                                             : bole_pkg::POS_W'($urandom_range(0, 64));
        counted = 1'b1;
        if (roll < (growing ? 55 : 15)) begin
            r = make_req(bole_pkg::OP_APPEND, v, p);
        end else if (roll < 97) begin
            case ($urandom_range(0, 4))
                0: r = make_req(bole_pkg::OP_DEL_HEAD, v, p);
                1: r = make_req(bole_pkg::OP_DEL_TAIL, v, p);
                2: r = make_req(bole_pkg::OP_DEL_POS, v, p);
                3: begin
                    // mostly hit a value that is actually held
                    if (sb.fill != 0 && $urandom_range(0, 9) < 7)
                        v = sb.entries[$urandom_range(0, sb.fill - 1)];
                    r = make_req(bole_pkg::OP_DEL_VAL, v, p);
                end
                default: r = make_req(bole_pkg::OP_READ, v, p);
            endcase
        end else begin
            r.op       = bole_pkg::OP_W'($urandom_range(6, 7));
            r.value    = v;
            r.position = p;
            counted    = 1'b0;
        end
        send_op(r);
    endtask

    // result side: check on every completed transaction, stall at random
    initial begin
        rsp_if.ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (rst_n && rsp_if.valid && rsp_if.ready) sb.check_result(rsp_if.payload);
            rsp_if.ready <= no_gaps || ($urandom_range(0, 99) >= 16);
        end
    end

    initial begin
        logic signed [bole_pkg::VAL_W-1:0] fill_vals [LIST_DEPTH];
        int  done_ops;
        bit  growing;
        bit  counted;

        fill_vals = '{
            32'sh8000_0000, 32'sh7fff_ffff, 0, -1, 5, 1, 5, 2,
            32'sh5555_5555, -32'sh2aaa_aaab, 7, -8, 100, -100, 3, 42
        };
        sb = new();
        rst_n          <= 1'b0;
        req_if.valid   <= 1'b0;
        req_if.payload <= '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty list: read-out and every delete flavor
        send_op(make_req(bole_pkg::OP_READ, '0, '0));
        send_op(make_req(bole_pkg::OP_DEL_HEAD, '0, '0));
        send_op(make_req(bole_pkg::OP_DEL_TAIL, '0, '0));
        send_op(make_req(bole_pkg::OP_DEL_POS, '0, 7'd1));
        send_op(make_req(bole_pkg::OP_DEL_VAL, '0, '0));
        // fill to the top, then one more append
        foreach (fill_vals[i]) send_op(make_req(bole_pkg::OP_APPEND, fill_vals[i], '0));
        send_op(make_req(bole_pkg::OP_APPEND, 32'sd99, '0));
        send_op(make_req(bole_pkg::OP_READ, '0, '0));
        // duplicate value: only the first copy goes
        send_op(make_req(bole_pkg::OP_DEL_VAL, 32'sd5, '0));
        send_op(make_req(bole_pkg::OP_DEL_VAL, 32'sd12345, '0));
        send_op(make_req(bole_pkg::OP_DEL_POS, '0, '0));
        send_op(make_req(bole_pkg::OP_DEL_POS, '0, 7'd64));
        send_op(make_req(bole_pkg::OP_DEL_POS, '0, bole_pkg::POS_W'(sb.fill)));
        send_op(make_req(bole_pkg::OP_DEL_HEAD, '0, '0));
        send_op(make_req(bole_pkg::OP_DEL_TAIL, '0, '0));
        send_op(make_req(bole_pkg::OP_READ, '0, '0));

        done_ops = 0;
        growing  = 1'b0;
        while (done_ops < RANDOM_OPS) begin
            if (done_ops == 110) wait_drained();
            no_gaps = (done_ops >= 150 && done_ops < 200);
            if (sb.fill == LIST_DEPTH && $urandom_range(0, 3) == 0) growing = 1'b0;
            if (sb.fill == 0) growing = 1'b1;
            send_random_op(growing, counted);
            if (counted) done_ops++;
        end
        no_gaps = 1'b0;

        req_if.valid <= 1'b0;
        while (sb.expected_results.size() != 0) @(posedge clk);
        repeat (SETTLE_CYC) @(posedge clk);

        $display("run covered %0d list operations and %0d checked results",
                 sb.ops_seen, sb.results_checked);
        $display("statuses predicted: ok %0d, empty %0d, full %0d, bad position %0d, missing %0d",
                 sb.status_seen[bole_pkg::ST_OK], sb.status_seen[bole_pkg::ST_EMPTY],
                 sb.status_seen[bole_pkg::ST_FULL], sb.status_seen[bole_pkg::ST_BADPOS],
                 sb.status_seen[bole_pkg::ST_NOTFOUND]);
        if (sb.errors == 0) begin
            $display("testbench: clean");
        end else begin
            $display("testbench: errors");
        end
        $finish;
    end

    // watchdog for a hung handshake
    initial begin
        #5_000_000;
        $display("testbench: errors");
        $finish;
    end

endmodule
